@@ sv/kseq_pkg.sv @@
// Shared constants, command codes and handshake types of the key sequence matcher.
package kseq_pkg;

	localparam int KEY_W       = 8;
	localparam int INDEX_W     = 4;
	localparam int TIMEOUT_W   = 16;
	localparam int IN_SEQ_N    = 4;
	localparam int ENTRIES_DEF = 16;
	localparam int SEQ_LEN_DEF = 4;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_FEED  = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic resolve;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_last;
	} dp_status_t;

endpackage

@@ sv/kseq_ctrl.sv @@
// Controller state machine that sequences accept, table scan, resolve and result beat.
module kseq_ctrl
	import kseq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t sts,
	output ctrl_cmd_t  ctl,
	output logic       busy,
	output logic       done
);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_SCAN    = 5'b00010,
		ST_WAIT    = 5'b00100,
		ST_RESOLVE = 5'b01000,
		ST_OUT     = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		ctl.accept  = 1'b0;
		ctl.rd_en   = 1'b0;
		ctl.resolve = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.accept = 1'b1;
					state_d    = sts.need_scan ? ST_SCAN : ST_OUT;
				end
			end
			ST_SCAN: begin
				ctl.rd_en = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_RESOLVE;
			end
			ST_RESOLVE: begin
				ctl.resolve = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_OUT);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |=> busy) else $error("busy not raised after an accepted beat");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held for more than one cycle");
	a_resolve_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.resolve |=> done) else $error("resolve not followed by a result beat");

endmodule

@@ sv/kseq_datapath.sv @@
// Datapath with sequence table memory, key buffer, idle timer and match evaluation.
module kseq_datapath
	import kseq_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int SEQ_LEN = SEQ_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_cmd_t            ctl,
	output dp_status_t           sts,
	input  logic [1:0]           cmd,
	input  logic [INDEX_W-1:0]   entry_index,
	input  logic [KEY_W-1:0]     entry_seq_0,
	input  logic [KEY_W-1:0]     entry_seq_1,
	input  logic [KEY_W-1:0]     entry_seq_2,
	input  logic [KEY_W-1:0]     entry_seq_3,
	input  logic [KEY_W-1:0]     entry_result_key,
	input  logic [KEY_W-1:0]     entry_result_mod,
	input  logic [KEY_W-1:0]     keycode,
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_wdata,
	output logic                 accepted,
	output logic                 resolved,
	output logic [KEY_W-1:0]     result_key,
	output logic [KEY_W-1:0]     result_modifier,
	output logic                 still_active
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(SEQ_LEN + 1);
	localparam int BW = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;
	localparam int SW = SEQ_LEN * KEY_W;
	localparam int MW = SW + 2 * KEY_W;

	logic [MW-1:0]        mem [ENTRIES];
	logic [ENTRIES-1:0]   valid_q;
	logic [KEY_W-1:0]     buf_q [SEQ_LEN];
	logic [CW-1:0]        count_q;
	logic                 collecting_q;
	logic [TIMEOUT_W-1:0] idle_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic                 defer_q;
	logic                 cancel_q;
	logic [IW-1:0]        scan_addr_q;
	logic                 rd_valid_s1;
	logic                 rd_live_s1;
	logic [MW-1:0]        rd_data_s1;
	logic                 prefix_q;
	logic                 exact_q;
	logic [KEY_W-1:0]     hit_key_q;
	logic [KEY_W-1:0]     hit_mod_q;

	logic [KEY_W-1:0]     in_seq [IN_SEQ_N];
	logic [SW-1:0]        wr_seq;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	logic                 feed_ok;
	logic                 room;
	logic                 tick_on;
	logic [TIMEOUT_W-1:0] idle_inc;
	logic                 expired;
	logic                 hit;
	logic [KEY_W-1:0]     e_key;
	logic [KEY_W-1:0]     e_mod;
	logic [CW-1:0]        e_len;
	logic                 e_run;
	logic                 e_head;
	logic                 e_prefix;
	logic                 e_exact;

	assign in_seq[0] = entry_seq_0;
	assign in_seq[1] = entry_seq_1;
	assign in_seq[2] = entry_seq_2;
	assign in_seq[3] = entry_seq_3;

	always_comb begin
		wr_seq = '0;
		for (int j = 0; j < SEQ_LEN; j++) begin
			if (j < IN_SEQ_N) begin
				wr_seq[j*KEY_W +: KEY_W] = in_seq[2'(j)];
			end
		end
	end

	assign wr_en   = ctl.accept && (cmd == CMD_WRITE) && (int'(entry_index) < ENTRIES);
	assign wr_addr = IW'(entry_index);

	assign feed_ok  = (cmd == CMD_FEED) && collecting_q && (keycode != '0);
	assign room     = (count_q < CW'(SEQ_LEN));
	assign tick_on  = (cmd == CMD_TICK) && collecting_q;
	assign idle_inc = (idle_q == '1) ? idle_q : idle_q + 1'b1;
	assign expired  = (idle_inc >= timeout_q);

	assign sts.need_scan = (feed_ok && room) || (tick_on && expired && (count_q != '0));
	assign sts.scan_last = (scan_addr_q == IW'(ENTRIES - 1));

	// Evaluation of the entry read in the previous cycle against the key buffer.
	always_comb begin
		e_key  = rd_live_s1 ? rd_data_s1[SW +: KEY_W] : '0;
		e_mod  = rd_data_s1[SW+KEY_W +: KEY_W];
		e_len  = '0;
		e_run  = 1'b1;
		e_head = 1'b1;
		for (int j = 0; j < SEQ_LEN; j++) begin
			if (rd_data_s1[j*KEY_W +: KEY_W] == '0) begin
				e_run = 1'b0;
			end
			if (e_run) begin
				e_len = e_len + 1'b1;
			end
			if ((CW'(j) < count_q) && (rd_data_s1[j*KEY_W +: KEY_W] != buf_q[j])) begin
				e_head = 1'b0;
			end
		end
		e_prefix = (e_key != '0) && (e_len > count_q) && e_head;
		e_exact  = (e_key != '0) && (e_len == count_q) && e_head;
	end

	assign hit = exact_q && !(defer_q && prefix_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {entry_result_mod, entry_result_key, wr_seq};
		end
		if (ctl.rd_en) begin
			rd_data_s1 <= mem[scan_addr_q];
			rd_live_s1 <= valid_q[scan_addr_q];
		end
		if (ctl.accept && feed_ok && room) begin
			buf_q[count_q[BW-1:0]] <= keycode;
		end
		if (rd_valid_s1 && e_exact && !exact_q) begin
			hit_key_q <= e_key;
			hit_mod_q <= e_mod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q         <= '0;
			count_q         <= '0;
			collecting_q    <= 1'b0;
			idle_q          <= '0;
			timeout_q       <= TIMEOUT_RESET;
			defer_q         <= 1'b0;
			cancel_q        <= 1'b0;
			scan_addr_q     <= '0;
			rd_valid_s1     <= 1'b0;
			prefix_q        <= 1'b0;
			exact_q         <= 1'b0;
			accepted        <= 1'b0;
			resolved        <= 1'b0;
			result_key      <= '0;
			result_modifier <= '0;
			still_active    <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_s1 <= ctl.rd_en;
			if (ctl.rd_en) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			if (rd_valid_s1) begin
				if (e_prefix) begin
					prefix_q <= 1'b1;
				end
				if (e_exact) begin
					exact_q <= 1'b1;
				end
			end
			if (ctl.accept) begin
				scan_addr_q     <= '0;
				prefix_q        <= 1'b0;
				exact_q         <= 1'b0;
				defer_q         <= (cmd == CMD_FEED);
				cancel_q        <= (cmd == CMD_TICK);
				accepted        <= feed_ok && room;
				resolved        <= 1'b0;
				result_key      <= '0;
				result_modifier <= '0;
				still_active    <= (cmd == CMD_START) ||
					(collecting_q && !(feed_ok && !room) && !(tick_on && expired));
				case (cmd)
					CMD_START: begin
						collecting_q <= 1'b1;
						count_q      <= '0;
						idle_q       <= '0;
					end
					CMD_FEED: begin
						if (feed_ok) begin
							if (room) begin
								count_q <= count_q + 1'b1;
								idle_q  <= '0;
							end else begin
								collecting_q <= 1'b0;
								count_q      <= '0;
							end
						end
					end
					CMD_TICK: begin
						if (tick_on) begin
							idle_q <= idle_inc;
							if (expired) begin
								collecting_q <= 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (ctl.resolve) begin
				resolved        <= hit;
				result_key      <= hit ? hit_key_q : '0;
				result_modifier <= hit ? hit_mod_q : '0;
				collecting_q    <= collecting_q && !hit;
				still_active    <= collecting_q && !hit;
				if (cancel_q) begin
					count_q <= '0;
				end
			end
		end
	end

	a_resolved_key: assert property (@(posedge clk) disable iff (!arst_n)
		resolved |-> (result_key != '0)) else $error("resolved beat with empty result key");
	a_accept_state: assert property (@(posedge clk) disable iff (!arst_n)
		accepted |-> (still_active || resolved)) else $error("accepted key lost its sequence");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SEQ_LEN)) else $error("key buffer count beyond its depth");

endmodule

@@ sv/key_sequence_matcher.sv @@
// Top level of the leader-key sequence matcher: controller and datapath.
//
// Commands arrive on cmd with their fields and are taken when start is high
// and busy is low. Write entry stores one table slot, start opens a sequence,
// feed key adds a key to the buffer and tick counts one idle millisecond.
// Every command gives exactly one result beat: done is high for one cycle and
// accepted, resolved, result_key, result_modifier and still_active are valid then.
// Write entry, start, ticks that do not time out with keys typed and feeds
// that are not taken give the result beat in the cycle after acceptance, with
// busy dropping in the cycle after it; no new command is taken during the beat.
// A feed that is taken, and a timeout with keys typed, scan the table one
// entry per cycle through the single read port of the table memory, then
// pass a wait and a resolve state before the result beat; no new command is
// taken until busy drops. The receiver cannot stall; the beat is lost if it
// is not taken. The user must write timeout_ms through cfg_we and cfg_wdata
// only while the block is idle; the block does not enforce this. Reset empties
// the table, clears the sequence state and sets timeout_ms to 1000; the block
// takes commands in the first cycle after reset.
module key_sequence_matcher
	import kseq_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int SEQ_LEN = SEQ_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           cmd,
	input  logic [INDEX_W-1:0]   entry_index,
	input  logic [KEY_W-1:0]     entry_seq_0,
	input  logic [KEY_W-1:0]     entry_seq_1,
	input  logic [KEY_W-1:0]     entry_seq_2,
	input  logic [KEY_W-1:0]     entry_seq_3,
	input  logic [KEY_W-1:0]     entry_result_key,
	input  logic [KEY_W-1:0]     entry_result_mod,
	input  logic [KEY_W-1:0]     keycode,
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_wdata,
	output logic                 done,
	output logic                 accepted,
	output logic                 resolved,
	output logic [KEY_W-1:0]     result_key,
	output logic [KEY_W-1:0]     result_modifier,
	output logic                 still_active
);

	ctrl_cmd_t  ctl;
	dp_status_t sts;

	kseq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	kseq_datapath #(
		.ENTRIES (ENTRIES),
		.SEQ_LEN (SEQ_LEN)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.cmd              (cmd),
		.entry_index      (entry_index),
		.entry_seq_0      (entry_seq_0),
		.entry_seq_1      (entry_seq_1),
		.entry_seq_2      (entry_seq_2),
		.entry_seq_3      (entry_seq_3),
		.entry_result_key (entry_result_key),
		.entry_result_mod (entry_result_mod),
		.keycode          (keycode),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.accepted         (accepted),
		.resolved         (resolved),
		.result_key       (result_key),
		.result_modifier  (result_modifier),
		.still_active     (still_active)
	);

endmodule

@@ tb/sv/tb_key_sequence_matcher.sv @@
// Self-checking testbench for the leader-key sequence matcher, with scoreboard and random commands.
`timescale 1ns / 1ps

module tb_key_sequence_matcher
	import kseq_pkg::*;
();

	typedef struct packed {
		logic [1:0]             cmd;
		logic [INDEX_W-1:0]     index;
		logic [3:0][KEY_W-1:0]  seq;
		logic [KEY_W-1:0]       res_key;
		logic [KEY_W-1:0]       res_mod;
		logic [KEY_W-1:0]       keycode;
	} kseq_item_t;

	typedef struct packed {
		logic             acc;
		logic             res;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] mod;
		logic             act;
	} kseq_beat_t;

	localparam int ITEM_W = $bits(kseq_item_t);

	class matcher_scoreboard;
		logic [KEY_W-1:0] seq_keys [ENTRIES_DEF][SEQ_LEN_DEF];
		logic [KEY_W-1:0] hit_key [ENTRIES_DEF];
		logic [KEY_W-1:0] hit_mod [ENTRIES_DEF];
		logic [KEY_W-1:0] typed [SEQ_LEN_DEF];
		int unsigned typed_n;
		bit collecting;
		int unsigned idle_ms;
		int unsigned timeout_ms;
		int unsigned errors;
		kseq_beat_t expected_beats [$];

		function new();
			for (int e = 0; e < ENTRIES_DEF; e++) begin
				hit_key[e] = '0;
				hit_mod[e] = '0;
				for (int j = 0; j < SEQ_LEN_DEF; j++)
					seq_keys[e][j] = '0;
			end
			for (int j = 0; j < SEQ_LEN_DEF; j++)
				typed[j] = '0;
			typed_n = 0;
			collecting = 0;
			idle_ms = 0;
			timeout_ms = TIMEOUT_RESET;
			errors = 0;
		endfunction

		function int unsigned pending();
			return expected_beats.size();
		endfunction

		function int unsigned length_of(int unsigned e);
			int unsigned n;
			n = 0;
			while (n < SEQ_LEN_DEF && seq_keys[e][n] != 0)
				n++;
			return n;
		endfunction

		function bit head_matches(int unsigned e);
			for (int unsigned j = 0; j < typed_n && j < SEQ_LEN_DEF; j++)
				if (seq_keys[e][j] != typed[j])
					return 0;
			return 1;
		endfunction

		function bit exact_hit(bit defer, output logic [KEY_W-1:0] key,
				output logic [KEY_W-1:0] mod);
			key = '0;
			mod = '0;
			if (defer) begin
				for (int unsigned e = 0; e < ENTRIES_DEF; e++)
					if (hit_key[e] != 0 && length_of(e) > typed_n && head_matches(e))
						return 0;
			end
			for (int unsigned e = 0; e < ENTRIES_DEF; e++) begin
				if (hit_key[e] != 0 && length_of(e) == typed_n && head_matches(e)) begin
					key = hit_key[e];
					mod = hit_mod[e];
					collecting = 0;
					return 1;
				end
			end
			return 0;
		endfunction

		function void note_command(kseq_item_t it);
			kseq_beat_t b;
			b = '0;
			case (it.cmd)
				CMD_WRITE: begin
					for (int j = 0; j < SEQ_LEN_DEF; j++)
						seq_keys[it.index][j] = (j < IN_SEQ_N) ? it.seq[j] : '0;
					hit_key[it.index] = it.res_key;
					hit_mod[it.index] = it.res_mod;
				end
				CMD_START: begin
					collecting = 1;
					typed_n = 0;
					idle_ms = 0;
				end
				CMD_FEED: begin
					if (collecting && it.keycode != 0) begin
						if (typed_n < SEQ_LEN_DEF) begin
							typed[typed_n] = it.keycode;
							typed_n++;
							idle_ms = 0;
							b.acc = 1;
							b.res = exact_hit(1, b.key, b.mod);
						end else begin
							collecting = 0;
							typed_n = 0;
						end
					end
				end
				CMD_TICK: begin
					if (collecting) begin
						if (idle_ms < 16'hFFFF)
							idle_ms++;
						if (idle_ms >= timeout_ms) begin
							if (typed_n > 0)
								b.res = exact_hit(0, b.key, b.mod);
							collecting = 0;
							typed_n = 0;
						end
					end
				end
				default: begin
				end
			endcase
			if (!b.res) begin
				b.key = '0;
				b.mod = '0;
			end
			b.act = collecting;
			expected_beats.push_back(b);
		endfunction

		function void compare(string field, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0h, actual %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_beat(logic acc, logic res, logic [KEY_W-1:0] key,
				logic [KEY_W-1:0] mod, logic act);
			kseq_beat_t want;
			if (expected_beats.size() == 0) begin
				$error("result beat with no command outstanding");
				errors++;
				return;
			end
			want = expected_beats.pop_front();
			compare("accepted", KEY_W'(want.acc), KEY_W'(acc));
			compare("resolved", KEY_W'(want.res), KEY_W'(res));
			compare("result_key", want.key, key);
			compare("result_modifier", want.mod, mod);
			compare("still_active", KEY_W'(want.act), KEY_W'(act));
		endfunction
	endclass

	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           cmd;
	logic [INDEX_W-1:0]   entry_index;
	logic [KEY_W-1:0]     entry_seq_0;
	logic [KEY_W-1:0]     entry_seq_1;
	logic [KEY_W-1:0]     entry_seq_2;
	logic [KEY_W-1:0]     entry_seq_3;
	logic [KEY_W-1:0]     entry_result_key;
	logic [KEY_W-1:0]     entry_result_mod;
	logic [KEY_W-1:0]     keycode;
	logic                 cfg_we;
	logic [TIMEOUT_W-1:0] cfg_wdata;
	logic                 done;
	logic                 accepted;
	logic                 resolved;
	logic [KEY_W-1:0]     result_key;
	logic [KEY_W-1:0]     result_modifier;
	logic                 still_active;

	matcher_scoreboard matcher;
	bit gaps_on;
	int unsigned issued;
	int unsigned cycles;

	key_sequence_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.entry_index(entry_index),
		.entry_seq_0(entry_seq_0),
		.entry_seq_1(entry_seq_1),
		.entry_seq_2(entry_seq_2),
		.entry_seq_3(entry_seq_3),
		.entry_result_key(entry_result_key),
		.entry_result_mod(entry_result_mod),
		.keycode(keycode),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.accepted(accepted),
		.resolved(resolved),
		.result_key(result_key),
		.result_modifier(result_modifier),
		.still_active(still_active)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_key_sequence_matcher NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			matcher.check_beat(accepted, resolved, result_key, result_modifier, still_active);
	end

	function automatic kseq_item_t blank(input logic [1:0] c);
		kseq_item_t it;
		it = ITEM_W'({$urandom, $urandom});
		it.cmd = c;
		return it;
	endfunction

	function automatic kseq_item_t entry(input logic [INDEX_W-1:0] idx,
			input logic [KEY_W-1:0] s0, input logic [KEY_W-1:0] s1,
			input logic [KEY_W-1:0] s2, input logic [KEY_W-1:0] s3,
			input logic [KEY_W-1:0] rk, input logic [KEY_W-1:0] rm);
		kseq_item_t it;
		it = blank(CMD_WRITE);
		it.index = idx;
		it.seq = {s3, s2, s1, s0};
		it.res_key = rk;
		it.res_mod = rm;
		return it;
	endfunction

	function automatic kseq_item_t feed(input logic [KEY_W-1:0] kc);
		kseq_item_t it;
		it = blank(CMD_FEED);
		it.keycode = kc;
		return it;
	endfunction

	// A small alphabet keeps typed keys colliding with table entries.
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 8'hFF;
			1: return KEY_W'($urandom_range(1, 255));
			default: return KEY_W'($urandom_range(1, 6));
		endcase
	endfunction

	task automatic issue(input kseq_item_t it);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= it.cmd;
		entry_index <= it.index;
		entry_seq_0 <= it.seq[0];
		entry_seq_1 <= it.seq[1];
		entry_seq_2 <= it.seq[2];
		entry_seq_3 <= it.seq[3];
		entry_result_key <= it.res_key;
		entry_result_mod <= it.res_mod;
		keycode <= it.keycode;
		@(posedge clk);
		while (busy) @(posedge clk);
		matcher.note_command(it);
		issued++;
	endtask

	task automatic tick_run(input int unsigned n);
		repeat (n) issue(blank(CMD_TICK));
	endtask

	task automatic set_timeout(input logic [TIMEOUT_W-1:0] v);
		start <= 1'b0;
		while (matcher.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= TIMEOUT_W'($urandom);
		matcher.timeout_ms = v;
	endtask

	function automatic int unsigned tick_span();
		return (matcher.timeout_ms > 40) ? 40 : matcher.timeout_ms;
	endfunction

	task automatic random_write();
		kseq_item_t it;
		int unsigned len;
		it = blank(CMD_WRITE);
		len = $urandom_range(0, IN_SEQ_N);
		for (int j = 0; j < IN_SEQ_N; j++) begin
			if (j < len)
				it.seq[j] = pick_key();
			else if (j == len)
				it.seq[j] = '0;
		end
		it.res_key = ($urandom_range(0, 6) == 0) ? '0 : KEY_W'($urandom_range(1, 255));
		issue(it);
	endtask

	task automatic random_sequence();
		kseq_item_t it;
		int unsigned slot;
		int unsigned n;
		bit follow;
		issue(blank(CMD_START));
		follow = ($urandom_range(0, 2) != 0);
		slot = $urandom_range(0, ENTRIES_DEF - 1);
		n = follow ? matcher.length_of(slot) + ($urandom_range(0, 3) == 0)
			: $urandom_range(1, SEQ_LEN_DEF + 1);
		if (n == 0)
			n = 1;
		for (int unsigned k = 0; k < n; k++) begin
			it = feed(pick_key());
			if (follow && k < SEQ_LEN_DEF && matcher.seq_keys[slot][k] != 0)
				it.keycode = matcher.seq_keys[slot][k];
			if ($urandom_range(0, 15) == 0)
				it.keycode = '0;
			issue(it);
			if ($urandom_range(0, 3) == 0)
				tick_run($urandom_range(0, tick_span()));
		end
		if ($urandom_range(0, 2) == 0)
			tick_run(tick_span() + 1);
	endtask

	task automatic random_phase(input int unsigned quota);
		int unsigned first;
		first = issued;
		while (issued - first < quota) begin
			gaps_on = ($urandom_range(0, 2) != 0);
			case ($urandom_range(0, 9))
				0, 1: random_write();
				2: issue(blank(2'($urandom_range(0, 3))));
				default: random_sequence();
			endcase
		end
	endtask

	initial begin
		logic [TIMEOUT_W-1:0] steps [6];
		matcher = new();
		gaps_on = 1;
		issued = 0;
		cycles = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_WRITE;
		entry_index <= '0;
		entry_seq_0 <= '0;
		entry_seq_1 <= '0;
		entry_seq_2 <= '0;
		entry_seq_3 <= '0;
		entry_result_key <= '0;
		entry_result_mod <= '0;
		keycode <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		issue(feed(8'h04));
		issue(blank(CMD_TICK));
		issue(entry(4'd0, 8'h04, 8'h05, 8'h00, 8'h00, 8'h10, 8'h02));
		issue(entry(4'd1, 8'h04, 8'h05, 8'h06, 8'h00, 8'h11, 8'h04));
		issue(entry(4'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		issue(entry(4'd3, 8'h04, 8'h00, 8'h00, 8'h00, 8'h13, 8'h01));
		// Keys after the first zero must take no part in matching.
		issue(entry(4'd15, 8'h07, 8'h00, 8'h08, 8'h09, 8'h12, 8'h80));
		issue(entry(4'd4, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF));
		issue(blank(CMD_START));
		issue(feed(8'h00));
		issue(feed(8'h04));
		issue(feed(8'h05));
		issue(feed(8'h06));
		issue(blank(CMD_START));
		issue(blank(CMD_START));
		repeat (4) issue(feed(8'hFF));
		issue(blank(CMD_START));
		issue(feed(8'h07));
		issue(blank(CMD_START));
		issue(feed(8'h09));
		issue(feed(8'h01));
		issue(feed(8'h02));
		issue(feed(8'h03));
		issue(feed(8'h01));
		issue(blank(CMD_START));
		issue(feed(8'h04));
		tick_run(TIMEOUT_RESET);

		steps[0] = 16'd0;
		steps[1] = 16'd1;
		steps[2] = 16'd3;
		steps[3] = TIMEOUT_W'($urandom_range(2, 40));
		steps[4] = 16'd25;
		steps[5] = 16'd1000;
		foreach (steps[i]) begin
			set_timeout(steps[i]);
			random_phase(70);
		end

		gaps_on = 0;
		set_timeout(16'd2);
		issue(blank(CMD_START));
		issue(feed(8'h04));
		tick_run(2);
		set_timeout(16'hFFFF);
		issue(entry(4'd3, 8'h04, 8'h00, 8'h00, 8'h00, 8'h13, 8'h01));
		issue(blank(CMD_START));
		issue(feed(8'h04));
		tick_run(20);
		issue(blank(CMD_START));
		issue(feed(pick_key()));
		tick_run(3);

		start <= 1'b0;
		while (matcher.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (matcher.errors == 0)
			$display("tb_key_sequence_matcher OK");
		else
			$display("tb_key_sequence_matcher NOT OK");
		$finish;
	end

endmodule
